### hdl/ifd_pkg.sv
// Shared types and constants for the interpolating fractional delay line.
`timescale 1ns / 1ps
package ifd_pkg;
	localparam int SAMPLE_W = 24;
	localparam int LAG_W    = 29;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int REG_IDX_W = 1;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_PUT  = 2'd1,
		KIND_GET  = 2'd2,
		KIND_NONE = 2'd3
	} ifd_kind_t;

	localparam logic [REG_IDX_W-1:0] REG_TICK_DELAY = 1'b0;

	// per-item control that travels down the pipeline
	typedef struct packed {
		logic vld;
		logic wr;
		logic rd;
	} ifd_ctl_t;
endpackage

### hdl/ifd_if.sv
// Item channel interfaces: request (input items) and response (result items).
`timescale 1ns / 1ps
interface ifd_req_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          kind;
	logic signed [ifd_pkg::SAMPLE_W-1:0] sample_in;
	logic [ifd_pkg::LAG_W-1:0]           tap_lag;

	modport source(output valid, kind, sample_in, tap_lag, input ready);
	modport sink(input valid, kind, sample_in, tap_lag, output ready);
endinterface

interface ifd_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [ifd_pkg::SAMPLE_W-1:0] sample_out;

	modport source(output valid, sample_out, input ready);
	modport sink(input valid, sample_out, output ready);
endinterface

### hdl/ifd_wrap.sv
// Read position pipeline: lag modulo store length, then entry addresses and blend weight.
`timescale 1ns / 1ps
module ifd_wrap #(
	parameter int L_LEN     = 4098,
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ifd_pkg::ifd_ctl_t                   ctl_in,
	input  logic [ifd_pkg::LAG_W-1:0]           lag_in,
	input  logic [$clog2(L_LEN)-1:0]            w_in,
	input  logic signed [ifd_pkg::SAMPLE_W-1:0] smp_in,
	output ifd_pkg::ifd_ctl_t                   ctl_out,
	output logic [$clog2(L_LEN)-1:0]            waddr_out,
	output logic signed [ifd_pkg::SAMPLE_W-1:0] wdata_out,
	output logic [$clog2(L_LEN)-1:0]            i0_out,
	output logic [$clog2(L_LEN)-1:0]            i1_out,
	output logic [FRAC_BITS:0]                  alpha_out
);
	import ifd_pkg::*;

	localparam int AW      = $clog2(L_LEN);
	localparam int WHOLE_W = LAG_W - FRAC_BITS;
	localparam int LW      = $clog2(L_LEN + 1);
	localparam int NSTEP   = (WHOLE_W >= LW) ? (WHOLE_W - LW + 1) : 1;
	localparam int CW      = ((WHOLE_W > LW) ? WHOLE_W : LW) + 1;
	localparam logic [AW-1:0] LAST = AW'(L_LEN - 1);

	// stage 1 chain: the registered input, then one entry per compare-subtract step of the modulo
	ifd_ctl_t                   ctl_s1   [0:NSTEP];
	logic [CW-1:0]              whole_s1 [0:NSTEP];
	logic                       fz_s1    [0:NSTEP];
	logic [FRAC_BITS:0]         alpha_s1 [0:NSTEP];
	logic [AW-1:0]              w_s1     [0:NSTEP];
	logic signed [SAMPLE_W-1:0] smp_s1   [0:NSTEP];

	ifd_ctl_t                   ctl_s2, ctl_s3;
	logic [AW-1:0]              base_s2;
	logic                       fz_s2;
	logic [FRAC_BITS:0]         alpha_s2, alpha_s3;
	logic [AW-1:0]              w_s2, w_s3;
	logic signed [SAMPLE_W-1:0] smp_s2, smp_s3;
	logic [AW-1:0]              i0_s3, i1_s3;

	logic [FRAC_BITS-1:0]       frac;
	logic [FRAC_BITS:0]         alpha;
	logic [AW:0]                diff;
	logic [AW-1:0]              base;

	always_comb begin
		frac  = lag_in[FRAC_BITS-1:0];
		alpha = (|frac) ? ((FRAC_BITS+1)'(longint'(1) << FRAC_BITS) - {1'b0, frac}) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NSTEP; k++) ctl_s1[k] <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1[0] <= ctl_in;
			for (int k = 0; k < NSTEP; k++) ctl_s1[k+1] <= ctl_s1[k];
			ctl_s2 <= ctl_s1[NSTEP];
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		whole_s1[0] <= CW'(lag_in[LAG_W-1:FRAC_BITS]);
		fz_s1[0]    <= |frac;
		alpha_s1[0] <= alpha;
		w_s1[0]     <= w_in;
		smp_s1[0]   <= smp_in;
	end

	for (genvar g = 0; g < NSTEP; g++) begin : g_red
		localparam logic [CW-1:0] STEP_V = CW'(longint'(L_LEN) << (NSTEP - 1 - g));
		always_ff @(posedge clk) begin
			whole_s1[g+1] <= (whole_s1[g] >= STEP_V) ? (whole_s1[g] - STEP_V) : whole_s1[g];
			fz_s1[g+1]    <= fz_s1[g];
			alpha_s1[g+1] <= alpha_s1[g];
			w_s1[g+1]     <= w_s1[g];
			smp_s1[g+1]   <= smp_s1[g];
		end
	end

	// w - whole, brought back into [0, L)
	always_comb begin
		diff = {1'b0, w_s1[NSTEP]} - {1'b0, whole_s1[NSTEP][AW-1:0]};
		base = diff[AW] ? (diff[AW-1:0] + AW'(L_LEN)) : diff[AW-1:0];
	end

	always_ff @(posedge clk) begin
		base_s2  <= base;
		fz_s2    <= fz_s1[NSTEP];
		alpha_s2 <= alpha_s1[NSTEP];
		w_s2     <= w_s1[NSTEP];
		smp_s2   <= smp_s1[NSTEP];

		// a nonzero fraction moves the lower entry one further back
		if (fz_s2) begin
			i0_s3 <= (base_s2 == '0) ? LAST : (base_s2 - AW'(1));
			i1_s3 <= base_s2;
		end else begin
			i0_s3 <= base_s2;
			i1_s3 <= (base_s2 == LAST) ? '0 : (base_s2 + AW'(1));
		end
		alpha_s3 <= alpha_s2;
		w_s3     <= w_s2;
		smp_s3   <= smp_s2;
	end

	assign ctl_out   = ctl_s3;
	assign waddr_out = w_s3;
	assign wdata_out = smp_s3;
	assign i0_out    = i0_s3;
	assign i1_out    = i1_s3;
	assign alpha_out = alpha_s3;
endmodule

### hdl/ifd_store.sv
// Sample store: one write and two reads a cycle, write forwarding, clearing pass after reset.
`timescale 1ns / 1ps
module ifd_store #(
	parameter int L_LEN     = 4098,
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ifd_pkg::ifd_ctl_t                   ctl_in,
	input  logic [$clog2(L_LEN)-1:0]            waddr,
	input  logic signed [ifd_pkg::SAMPLE_W-1:0] wdata,
	input  logic [$clog2(L_LEN)-1:0]            raddr0,
	input  logic [$clog2(L_LEN)-1:0]            raddr1,
	input  logic [FRAC_BITS:0]                  alpha_in,
	output logic                                busy,
	output ifd_pkg::ifd_ctl_t                   ctl_out,
	output logic signed [ifd_pkg::SAMPLE_W-1:0] x0,
	output logic signed [ifd_pkg::SAMPLE_W-1:0] x1,
	output logic [FRAC_BITS:0]                  alpha_out
);
	import ifd_pkg::*;

	localparam int AW = $clog2(L_LEN);
	localparam logic [AW-1:0] LAST = AW'(L_LEN - 1);

	logic signed [SAMPLE_W-1:0] mem [0:L_LEN-1];

	logic                       clr_on_q;
	logic [AW-1:0]              clr_q;
	logic                       we;
	logic [AW-1:0]              wa;
	logic signed [SAMPLE_W-1:0] wd;

	ifd_ctl_t                   ctl_s1;
	logic signed [SAMPLE_W-1:0] rd0_s1, rd1_s1, wd_s1;
	logic                       hit0_s1, hit1_s1;
	logic [FRAC_BITS:0]         alpha_s1;

	always_comb begin
		we = clr_on_q || (ctl_in.vld && ctl_in.wr);
		wa = clr_on_q ? clr_q : waddr;
		wd = clr_on_q ? '0 : wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_on_q <= 1'b1;
			clr_q    <= '0;
			ctl_s1   <= '0;
		end else begin
			if (clr_on_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == LAST) clr_on_q <= 1'b0;
			end
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd0_s1 <= mem[raddr0];
		rd1_s1 <= mem[raddr1];
	end

	// a tick reads the entry it writes in the same cycle: take the new sample
	always_ff @(posedge clk) begin
		hit0_s1  <= ctl_in.vld && ctl_in.wr && (raddr0 == waddr);
		hit1_s1  <= ctl_in.vld && ctl_in.wr && (raddr1 == waddr);
		wd_s1    <= wdata;
		alpha_s1 <= alpha_in;
	end

	assign busy      = clr_on_q;
	assign ctl_out   = ctl_s1;
	assign x0        = hit0_s1 ? wd_s1 : rd0_s1;
	assign x1        = hit1_s1 ? wd_s1 : rd1_s1;
	assign alpha_out = alpha_s1;
endmodule

### hdl/ifd_interp.sv
// Linear blend of two neighboring entries, floor of the fixed-point result.
`timescale 1ns / 1ps
module ifd_interp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ifd_pkg::ifd_ctl_t                   ctl_in,
	input  logic signed [ifd_pkg::SAMPLE_W-1:0] x0,
	input  logic signed [ifd_pkg::SAMPLE_W-1:0] x1,
	input  logic [FRAC_BITS:0]                  alpha_in,
	output logic                                vld_out,
	output logic signed [ifd_pkg::SAMPLE_W-1:0] y_out
);
	import ifd_pkg::*;

	localparam int DW    = SAMPLE_W + 1;
	localparam int PW    = DW + FRAC_BITS + 2;
	localparam int ACC_W = PW + 1;

	logic                       vld_s1, vld_s2, vld_s3;
	logic signed [DW-1:0]       diff_s1;
	logic signed [SAMPLE_W-1:0] x0_s1, x0_s2;
	logic [FRAC_BITS:0]         alpha_s1;
	logic signed [PW-1:0]       prod_s2;
	logic signed [SAMPLE_W-1:0] y_s3;
	logic signed [ACC_W-1:0]    acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= ctl_in.vld && ctl_in.rd;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		acc = (ACC_W'(x0_s2) <<< FRAC_BITS) + ACC_W'(prod_s2);
	end

	always_ff @(posedge clk) begin
		diff_s1  <= DW'(x1) - DW'(x0);
		x0_s1    <= x0;
		alpha_s1 <= alpha_in;
		prod_s2  <= PW'(diff_s1) * PW'($signed({1'b0, alpha_s1}));
		x0_s2    <= x0_s1;
		// dropping the low bits of a two's complement value rounds toward minus infinity
		y_s3     <= acc[FRAC_BITS +: SAMPLE_W];
	end

	assign vld_out = vld_s3;
	assign y_out   = y_s3;
endmodule

### hdl/ifd_ofifo.sv
// Result queue between the pipeline and the response channel.
`timescale 1ns / 1ps
module ifd_ofifo #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic signed [ifd_pkg::SAMPLE_W-1:0] din,
	input  logic                                pop_ready,
	output logic                                valid,
	output logic signed [ifd_pkg::SAMPLE_W-1:0] dout
);
	import ifd_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [SAMPLE_W-1:0] buf_q [0:DEPTH-1];
	logic [PW-1:0]              wp_q, rp_q;
	logic [CW-1:0]              cnt_q;
	logic                       pop;

	assign valid = (cnt_q != '0);
	assign pop   = valid && pop_ready;
	assign dout  = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= din;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < CW'(DEPTH)) || pop)
		else $error("result queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("result queue count out of range");
endmodule

### hdl/interp_fractional_delay_line.sv
// Top level of the linear interpolating fractional delay line.
`timescale 1ns / 1ps
// Usage:
//   req carries items: kind (tick, put, get), sample_in and tap_lag. A tick writes
//   sample_in and returns the tap at the tick_delay register; a put only writes;
//   a get returns the tap at tap_lag without writing. kind 3 is dropped.
//   rsp carries one sample_out per tick or get, in item order.
//   tick_delay is written over the APB port at byte address 0 (13.16 format at the
//   default FRAC_BITS) while no item is in flight; pready is always high.
// Timing:
//   One item a cycle while req.ready is high. NSTEP compare-subtract stages reduce
//   the lag modulo the store length. The store does one write and two reads each
//   cycle, all at the same pipeline stage, so items never overtake each other.
// Reset:
//   The write pointer goes to half the store length, tick_delay to the same number
//   of whole samples, and a clearing pass zeroes the store: req.ready stays low until
//   that pass has gone through every entry.
// Stall:
//   Results wait in a queue sized for the pipeline; req.ready drops while clearing and
//   when queue and pipeline hold as many pending results as the queue has room.
module interp_fractional_delay_line #(
	parameter int MAX_DELAY = 4096,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ifd_req_if.sink                           req,
	ifd_rsp_if.source                         rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ifd_pkg::APB_AW-1:0]        paddr,
	input  logic [ifd_pkg::APB_DW-1:0]        pwdata,
	output logic [ifd_pkg::APB_DW-1:0]        prdata,
	output logic                              pready
);
	import ifd_pkg::*;

	localparam int L_LEN   = MAX_DELAY + 2;
	localparam int AW      = $clog2(L_LEN);
	localparam int WHOLE_W = LAG_W - FRAC_BITS;
	localparam int LW      = $clog2(L_LEN + 1);
	localparam int NSTEP   = (WHOLE_W >= LW) ? (WHOLE_W - LW + 1) : 1;
	localparam int LAT     = NSTEP + 8;
	localparam int FIFO_D  = 1 << $clog2(LAT + 2);
	localparam int CNT_W   = $clog2(FIFO_D + 1);
	localparam logic [AW-1:0]    W_RST   = AW'(L_LEN / 2);
	localparam logic [AW-1:0]    LAST    = AW'(L_LEN - 1);
	localparam logic [LAG_W-1:0] DLY_RST = LAG_W'(longint'(L_LEN / 2) << FRAC_BITS);

	logic [AW-1:0]    wptr_q;
	logic [LAG_W-1:0] dly_q;
	logic [CNT_W-1:0] cnt_q;

	logic             busy;
	logic             acc;
	logic             pop;
	logic             is_wr, is_rd;
	logic             cfg_wr;
	ifd_ctl_t         ctl_in;
	logic [LAG_W-1:0] lag_sel;

	ifd_ctl_t                   ctl_w, ctl_m;
	logic [AW-1:0]              waddr_w, i0_w, i1_w;
	logic signed [SAMPLE_W-1:0] wdata_w, x0_m, x1_m, y_i;
	logic [FRAC_BITS:0]         alpha_w, alpha_m;
	logic                       push_i;

	// input side
	always_comb begin
		is_wr   = (req.kind == KIND_TICK) || (req.kind == KIND_PUT);
		is_rd   = (req.kind == KIND_TICK) || (req.kind == KIND_GET);
		acc     = req.valid && req.ready;
		pop     = rsp.valid && rsp.ready;
		ctl_in.vld = acc && (is_wr || is_rd);
		ctl_in.wr  = is_wr;
		ctl_in.rd  = is_rd;
		lag_sel = (req.kind == KIND_TICK) ? dly_q : req.tap_lag;
	end

	assign req.ready = !busy && (cnt_q < CNT_W'(FIFO_D));

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[APB_AW-1:2] == REG_TICK_DELAY) ? APB_DW'(dly_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= W_RST;
			dly_q  <= DLY_RST;
			cnt_q  <= '0;
		end else begin
			if (acc && is_wr) wptr_q <= (wptr_q == LAST) ? '0 : (wptr_q + AW'(1));
			if (cfg_wr && (paddr[APB_AW-1:2] == REG_TICK_DELAY)) dly_q <= pwdata[LAG_W-1:0];
			// results owed: accepted reads not yet taken
			cnt_q <= cnt_q + CNT_W'(acc && is_rd) - CNT_W'(pop);
		end
	end

	ifd_wrap #(
		.L_LEN     (L_LEN),
		.FRAC_BITS (FRAC_BITS)
	) u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_in),
		.lag_in    (lag_sel),
		.w_in      (wptr_q),
		.smp_in    (req.sample_in),
		.ctl_out   (ctl_w),
		.waddr_out (waddr_w),
		.wdata_out (wdata_w),
		.i0_out    (i0_w),
		.i1_out    (i1_w),
		.alpha_out (alpha_w)
	);

	ifd_store #(
		.L_LEN     (L_LEN),
		.FRAC_BITS (FRAC_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_w),
		.waddr     (waddr_w),
		.wdata     (wdata_w),
		.raddr0    (i0_w),
		.raddr1    (i1_w),
		.alpha_in  (alpha_w),
		.busy      (busy),
		.ctl_out   (ctl_m),
		.x0        (x0_m),
		.x1        (x1_m),
		.alpha_out (alpha_m)
	);

	ifd_interp #(
		.FRAC_BITS (FRAC_BITS)
	) u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_m),
		.x0       (x0_m),
		.x1       (x1_m),
		.alpha_in (alpha_m),
		.vld_out  (push_i),
		.y_out    (y_i)
	);

	ifd_ofifo #(
		.DEPTH (FIFO_D)
	) u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_i),
		.din       (y_i),
		.pop_ready (rsp.ready),
		.valid     (rsp.valid),
		.dout      (rsp.sample_out)
	);

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_D))
		else $error("pending result count exceeds queue depth");
	a_wptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q <= LAST)
		else $error("write pointer outside store");
	a_rsp_owed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (cnt_q != '0))
		else $error("result offered with none owed");
endmodule

### dv/tb.sv
// Self-checking testbench for the interpolating fractional delay line.
`timescale 1ns / 1ps
module tb;
	import ifd_pkg::*;

	localparam int unsigned STORE_LEN = 4098;
	localparam int unsigned FRAC = 16;
	localparam int LIMIT = 400000;
	localparam int SETTLE = 40;
	localparam int HOLD_LEN = 400;
	localparam logic [LAG_W-1:0] LAG_ONES = '1;
	localparam logic [LAG_W-1:0] DELAY_RST = 29'(2049 << FRAC);

	typedef struct {
		ifd_kind_t                  kind;
		logic signed [SAMPLE_W-1:0] sample;
		logic [LAG_W-1:0]           lag;
	} dl_item_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	ifd_req_if req_ch();
	ifd_rsp_if rsp_ch();

	interp_fractional_delay_line DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// model of the delay store
	logic signed [SAMPLE_W-1:0] dl_mem [0:STORE_LEN-1];
	int unsigned wr_ptr;
	logic [LAG_W-1:0] tick_delay_m;

	dl_item_t send_q[$];
	logic signed [SAMPLE_W-1:0] want_q[$];
	int fail_cnt;
	int cycle_cnt;
	logic req_took;
	int burst_left, gap_left;
	int hold_left;
	bit hold_ask;
	int rx_cyc, stall_pct;

	function automatic void log_fail(string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%s", msg);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] interp_tap(logic [LAG_W-1:0] lag);
		int unsigned whole, frac, i0, i1;
		longint x0, x1, alpha, acc;
		whole = (lag >> FRAC) % STORE_LEN;
		frac = lag & 29'hFFFF;
		alpha = 0;
		i0 = (wr_ptr + STORE_LEN - whole) % STORE_LEN;
		// fractional lag reaches one entry further back
		if (frac != 0) begin
			i0 = (i0 + STORE_LEN - 1) % STORE_LEN;
			alpha = 65536 - frac;
		end
		i1 = (i0 + 1) % STORE_LEN;
		x0 = dl_mem[i0];
		x1 = dl_mem[i1];
		acc = x0 * 65536 + (x1 - x0) * alpha;
		return SAMPLE_W'(acc >>> FRAC);
	endfunction

	function automatic bit apply_item(dl_item_t it, output logic signed [SAMPLE_W-1:0] y);
		y = '0;
		case (it.kind)
			KIND_TICK: begin
				// write first, read relative to the pointer before the write
				dl_mem[wr_ptr] = it.sample;
				y = interp_tap(tick_delay_m);
				wr_ptr = (wr_ptr + 1) % STORE_LEN;
				return 1'b1;
			end
			KIND_PUT: begin
				dl_mem[wr_ptr] = it.sample;
				wr_ptr = (wr_ptr + 1) % STORE_LEN;
				return 1'b0;
			end
			KIND_GET: begin
				y = interp_tap(it.lag);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic dl_item_t mk_item(ifd_kind_t k, int s, logic [LAG_W-1:0] lag);
		dl_item_t it;
		it.kind = k;
		it.sample = SAMPLE_W'(s);
		it.lag = lag;
		return it;
	endfunction

	function automatic dl_item_t rand_item();
		dl_item_t it;
		int r;
		r = $urandom_range(99);
		if (r < 50)
			it.kind = KIND_TICK;
		else if (r < 68)
			it.kind = KIND_PUT;
		else if (r < 95)
			it.kind = KIND_GET;
		else
			it.kind = KIND_NONE;
		r = $urandom_range(99);
		if (r < 8)
			it.sample = 24'sh7FFFFF;
		else if (r < 16)
			it.sample = 24'sh800000;
		else if (r < 20)
			it.sample = (r < 18) ? 24'sh000000 : 24'shFFFFFF;
		else
			it.sample = SAMPLE_W'($urandom);
		r = $urandom_range(99);
		if (r < 40)
			it.lag = 29'({$urandom_range(20), 16'($urandom)});
		else if (r < 55)
			it.lag = 29'({$urandom_range(4090, 4100), 16'($urandom)});
		else if (r < 70)
			it.lag = 29'($urandom);
		else if (r < 80)
			it.lag = 29'({$urandom_range(4097), 16'h0000});
		else if (r < 90)
			it.lag = 29'({$urandom_range(4100), 16'hFFFF});
		else
			it.lag = 29'($urandom_range(16'hFFFF));
		return it;
	endfunction

	task automatic set_tick_delay(logic [LAG_W-1:0] v);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {REG_TICK_DELAY, 2'b00};
		pwdata = APB_DW'(v);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		tick_delay_m = v;
		// read back through a second transfer
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DW'(v))
			log_fail($sformatf("tick_delay readback: expected %h got %h", APB_DW'(v), prdata));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic wait_drained();
		while (send_q.size() != 0 || want_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_random(int n);
		repeat (n) send_q.push_back(rand_item());
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// item driver
	always @(negedge clk) begin
		logic offer;
		offer = 1'b0;
		if (req_took)
			send_q.delete(0);
		if (req_ch.valid && !req_took)
			offer = 1'b1;
		else if (send_q.size() != 0) begin
			if (gap_left != 0 && hold_left == 0)
				gap_left--;
			else begin
				offer = 1'b1;
				if (burst_left != 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(24);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		req_ch.valid <= offer;
		if (offer) begin
			req_ch.kind <= send_q[0].kind;
			req_ch.sample_in <= send_q[0].sample;
			req_ch.tap_lag <= send_q[0].lag;
		end
	end

	// result receiver: random stall duty, plus an occasional long hold
	always @(negedge clk) begin
		rx_cyc++;
		if (rx_cyc % 64 == 0)
			case ($urandom_range(4))
				0, 1: stall_pct = 0;
				2: stall_pct = 25;
				3: stall_pct = 50;
				default: stall_pct = 80;
			endcase
		if (hold_ask) begin
			hold_ask = 1'b0;
			hold_left <= HOLD_LEN;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// monitor and checker
	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] y;
		logic signed [SAMPLE_W-1:0] exp_s;
		dl_item_t it;
		req_took <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (want_q.size() == 0)
				log_fail($sformatf("unexpected item: sample_out %0d", rsp_ch.sample_out));
			else begin
				exp_s = want_q.pop_front();
				if (rsp_ch.sample_out !== exp_s)
					log_fail($sformatf("sample_out: expected %0d got %0d",
						exp_s, rsp_ch.sample_out));
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			it.kind = ifd_kind_t'(req_ch.kind);
			it.sample = req_ch.sample_in;
			it.lag = req_ch.tap_lag;
			if (apply_item(it, y))
				want_q.push_back(y);
		end
	end

	initial begin
		logic [LAG_W-1:0] settings [$];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = '0;
		req_ch.sample_in = '0;
		req_ch.tap_lag = '0;
		rsp_ch.ready = 1'b0;
		req_took = 1'b0;
		fail_cnt = 0;
		burst_left = 0;
		gap_left = 0;
		hold_left = 0;
		hold_ask = 1'b0;
		rx_cyc = 0;
		stall_pct = 0;
		for (int i = 0; i < STORE_LEN; i++)
			dl_mem[i] = '0;
		wr_ptr = STORE_LEN / 2;
		tick_delay_m = DELAY_RST;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items at the reset delay
		send_q.push_back(mk_item(KIND_TICK, 8388607, 0));
		send_q.push_back(mk_item(KIND_TICK, -8388608, 0));
		send_q.push_back(mk_item(KIND_PUT, 8388607, 0));
		send_q.push_back(mk_item(KIND_PUT, -8388608, 0));
		// halfway between the two extremes: rounds down to -1
		send_q.push_back(mk_item(KIND_GET, 0, 29'h18000));
		send_q.push_back(mk_item(KIND_GET, 0, 0));
		send_q.push_back(mk_item(KIND_GET, 0, 29'h10000));
		send_q.push_back(mk_item(KIND_GET, 0, 29'h20000));
		send_q.push_back(mk_item(KIND_GET, 0, 29'h00001));
		send_q.push_back(mk_item(KIND_GET, 0, 29'h0FFFF));
		send_q.push_back(mk_item(KIND_GET, 0, LAG_ONES));
		send_q.push_back(mk_item(KIND_GET, 0, 29'(STORE_LEN << FRAC)));
		send_q.push_back(mk_item(KIND_GET, 0, 29'(((STORE_LEN - 1) << FRAC) | 16'hFFFF)));
		send_q.push_back(mk_item(KIND_GET, 0, 29'h10000000));
		send_q.push_back(mk_item(KIND_NONE, 8388607, LAG_ONES));
		send_q.push_back(mk_item(KIND_TICK, 0, 0));
		send_q.push_back(mk_item(KIND_TICK, -1, LAG_ONES));
		send_q.push_back(mk_item(KIND_PUT, 24'h555555, 0));
		send_q.push_back(mk_item(KIND_PUT, 24'hAAAAAA, 0));
		send_q.push_back(mk_item(KIND_GET, 0, 29'h14000));
		send_q.push_back(mk_item(KIND_GET, 0, DELAY_RST));
		send_q.push_back(mk_item(KIND_GET, 0, DELAY_RST + 29'h10000));
		queue_random(20);
		wait_drained();

		settings.push_back('0);
		settings.push_back(29'h10000000);
		settings.push_back(LAG_ONES);
		settings.push_back(29'(((STORE_LEN - 1) << FRAC) | 16'hFFFF));
		settings.push_back(29'h00001);
		settings.push_back(29'h08000);
		settings.push_back(29'($urandom));
		settings.push_back(29'({$urandom_range(8), 16'($urandom)}));
		foreach (settings[p]) begin
			set_tick_delay(settings[p]);
			// receiver holds off while the sender keeps offering
			if (p == 2)
				hold_ask = 1'b1;
			queue_random(110);
			wait_drained();
		end

		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

### interp_fractional_delay_line.f
hdl/ifd_pkg.sv
hdl/ifd_if.sv
hdl/ifd_wrap.sv
hdl/ifd_store.sv
hdl/ifd_interp.sv
hdl/ifd_ofifo.sv
hdl/interp_fractional_delay_line.sv
dv/tb.sv
